/* src/ffpa_pkg.sv */
package ffpa_pkg;

  localparam int POOL_MAX_BYTES = 4096;
  localparam int HEADER_BYTES   = 8;
  localparam int SPLIT_SLACK    = 8;

  localparam int POOL_W  = 13;
  localparam int REQ_W   = 12;
  localparam int OFF_W   = 12;
  localparam int STAT_W  = 2;
  localparam int SIZE_W  = 13;
  localparam int ENTRY_W = SIZE_W + 1;
  localparam int ADDR_W  = $clog2(POOL_MAX_BYTES);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int SUM_W   = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 2;

  typedef logic [SUM_W-1:0] sum_t;

  localparam sum_t HDR_S       = sum_t'(HEADER_BYTES);
  localparam sum_t SPLIT_MIN_S = sum_t'(HEADER_BYTES + SPLIT_SLACK);
  localparam sum_t POOL_MAX_S  = sum_t'(POOL_MAX_BYTES);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_IGNORED = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_WALK,
    S_ALLOC_SPLIT,
    S_FREE_HEAD,
    S_FREE_MERGE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              free_mark;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic  start;
    logic  alloc_step;
    logic  alloc_take;
    logic  split_wr;
    logic  free_step;
    logic  free_wr;
    logic  free_wr_acc;
    logic  set_res;
    stat_t res_status;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic heap_none;
    logic free_oob;
    logic a_small;
    logic a_fit;
    logic a_split;
    logic a_new_in;
    logic a_last;
    logic f_stop;
    logic f_last;
    logic out_free;
  } sts_t;

endpackage

/* src/ffpa_ram.sv */
module ffpa_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ffpa_ctrl.sv */
module ffpa_ctrl import ffpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_mode,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_DONE;
    state_nxt      = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_mode == MODE_FREE) begin
            if (sts.free_oob) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_IGNORED;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FREE_HEAD;
            end
          end else if (sts.heap_none) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_NOSPACE;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_ALLOC_WALK;
          end
        end
      end
      S_ALLOC_WALK: begin
        if (sts.a_small) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NOSPACE;
          state_nxt      = S_RESP;
        end else if (sts.a_fit) begin
          cmd.alloc_take = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_DONE;
          state_nxt      = (sts.a_split && sts.a_new_in) ? S_ALLOC_SPLIT : S_RESP;
        end else if (sts.a_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NOSPACE;
          state_nxt      = S_RESP;
        end else begin
          cmd.alloc_step = 1'b1;
        end
      end
      S_ALLOC_SPLIT: begin
        cmd.split_wr = 1'b1;
        state_nxt    = S_RESP;
      end
      S_FREE_HEAD: begin
        if (sts.a_small || sts.f_last) begin
          cmd.free_wr    = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_DONE;
          state_nxt      = S_RESP;
        end else begin
          cmd.free_step = 1'b1;
          state_nxt     = S_FREE_MERGE;
        end
      end
      S_FREE_MERGE: begin
        if (sts.f_stop) begin
          cmd.free_wr     = 1'b1;
          cmd.free_wr_acc = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_status  = ST_DONE;
          state_nxt       = S_RESP;
        end else if (sts.f_last) begin
          cmd.free_wr    = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_DONE;
          state_nxt      = S_RESP;
        end else begin
          cmd.free_step = 1'b1;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/ffpa_dp.sv */
module ffpa_dp import ffpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [POOL_W-1:0] cfg_wr_data,
  input  logic              in_mode,
  input  logic [REQ_W-1:0]  in_req_bytes,
  input  logic [OFF_W-1:0]  in_payload_offset,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [OFF_W-1:0]  out_granted_offset
);

  logic [LEN_W-1:0]   heap_len_r;
  logic [REQ_W-1:0]   req_r;
  logic [ADDR_W-1:0]  p_r;
  logic [ADDR_W-1:0]  h_r;
  logic [ADDR_W-1:0]  n_r;
  logic [SIZE_W-1:0]  acc_r;
  logic [SIZE_W-1:0]  acc_nxt;
  logic [SIZE_W-1:0]  rest_r;
  logic               head_r;
  stat_t              res_status_r;
  logic [OFF_W-1:0]   grant_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [OFF_W-1:0]   out_grant_r;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  hdr_t               rd_hdr;

  sum_t len_s, cfg_len_s, off_in_s, h_in_s, rd_size_s, p_s, req_s;
  sum_t avail_s, rest_s, n_s, a_next_s, take_size_s, grant_s, nx_s;
  logic [SIZE_W:0]    sum_raw;
  logic [SIZE_W-1:0]  sum_sat;
  logic               cfg_ok;

  ffpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_MAX_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_hdr    = hdr_t'(ram_rdata);
  assign len_s     = sum_t'(heap_len_r);
  assign cfg_len_s = (sum_t'(cfg_wr_data) > POOL_MAX_S) ? POOL_MAX_S : sum_t'(cfg_wr_data);
  assign cfg_ok    = (cfg_len_s >= HDR_S);

  assign off_in_s = sum_t'(in_payload_offset);
  assign h_in_s   = off_in_s - HDR_S;

  // allocate walk
  assign rd_size_s   = sum_t'(rd_hdr.size);
  assign p_s         = sum_t'(p_r);
  assign req_s       = sum_t'(req_r);
  assign avail_s     = rd_size_s - HDR_S;
  assign rest_s      = avail_s - req_s;
  assign n_s         = p_s + HDR_S + req_s;
  assign a_next_s    = p_s + rd_size_s;
  assign take_size_s = HDR_S + req_s;
  assign grant_s     = p_s + HDR_S;

  // free merge, sizes saturate
  assign sum_raw = {1'b0, acc_r} + {1'b0, rd_hdr.size};
  assign sum_sat = sum_raw[SIZE_W] ? '1 : sum_raw[SIZE_W-1:0];
  assign acc_nxt = head_r ? rd_hdr.size : sum_sat;
  assign nx_s    = sum_t'(h_r) + sum_t'(acc_nxt);

  always_comb begin
    sts           = '0;
    sts.heap_none = (heap_len_r == '0);
    sts.free_oob  = (off_in_s >= len_s) || (off_in_s < HDR_S);
    sts.a_small   = (rd_size_s < HDR_S);
    sts.a_fit     = rd_hdr.free_mark && (avail_s > req_s);
    sts.a_split   = (rest_s > SPLIT_MIN_S);
    sts.a_new_in  = (n_s < len_s);
    sts.a_last    = (a_next_s >= len_s);
    sts.f_stop    = !rd_hdr.free_mark || (rd_size_s < HDR_S);
    sts.f_last    = (nx_s >= len_s);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cfg_wr_en) begin
      ram_we    = cfg_ok;
      ram_wdata = {1'b1, cfg_len_s[SIZE_W-1:0]};
    end else if (cmd.alloc_take) begin
      ram_we    = 1'b1;
      ram_waddr = p_r;
      ram_wdata = {1'b0, sts.a_split ? take_size_s[SIZE_W-1:0] : rd_hdr.size};
    end else if (cmd.split_wr) begin
      ram_we    = 1'b1;
      ram_waddr = n_r;
      ram_wdata = {1'b1, rest_r};
    end else if (cmd.free_wr) begin
      ram_we    = 1'b1;
      ram_waddr = h_r;
      ram_wdata = {1'b1, cmd.free_wr_acc ? acc_r : acc_nxt};
    end
  end

  always_comb begin
    ram_raddr = '0;
    if (cmd.start) begin
      ram_raddr = (in_mode == MODE_FREE) ? h_in_s[ADDR_W-1:0] : '0;
    end else if (cmd.alloc_step) begin
      ram_raddr = a_next_s[ADDR_W-1:0];
    end else if (cmd.free_step) begin
      ram_raddr = nx_s[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_len_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        heap_len_r <= cfg_ok ? cfg_len_s[LEN_W-1:0] : '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r   <= in_req_bytes;
      p_r     <= '0;
      h_r     <= h_in_s[ADDR_W-1:0];
      head_r  <= 1'b1;
      grant_r <= '0;
    end
    if (cmd.alloc_step) begin
      p_r <= a_next_s[ADDR_W-1:0];
    end
    if (cmd.alloc_take) begin
      grant_r <= grant_s[OFF_W-1:0];
      n_r     <= n_s[ADDR_W-1:0];
      rest_r  <= rest_s[SIZE_W-1:0];
    end
    if (cmd.free_step) begin
      acc_r  <= acc_nxt;
      head_r <= 1'b0;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_grant_r  <= grant_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_grant_r;

endmodule

/* src/first_fit_pool_allocator_top.sv */
// Channel  Direction  Handshake          Beat
// in       input      in_valid/in_stall  in_mode, in_req_bytes, in_payload_offset
// out      output     out_valid/out_stall out_status, out_granted_offset
// cfg      input      cfg_wr_en          cfg_wr_data (pool size, restarts heap)
//
// One beat at a time. Allocate: accept, one RAM read per header visited,
// a split write when a split puts a new header inside the pool, result load.
// Free: accept, head read, each following header read (merged or stopping),
// load. No heap or free out of range: accept and load only.
// rst_n (sync) empties the heap; header RAM is not cleared, a cfg write starts it.
// in_stall is high from acceptance until the result sits in the output register.
module first_fit_pool_allocator_top import ffpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [POOL_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [REQ_W-1:0]  in_req_bytes,
  input  logic [OFF_W-1:0]  in_payload_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [OFF_W-1:0]  out_granted_offset
);

  cmd_t cmd;
  sts_t sts;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffpa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_mode            (in_mode),
    .in_req_bytes       (in_req_bytes),
    .in_payload_offset  (in_payload_offset),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset)
  );

endmodule

/* src/ffpa_chk.sv */
module ffpa_chk import ffpa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] out_status,
  input logic [OFF_W-1:0]  out_granted_offset
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
                               && $stable(out_granted_offset))
    else $error("stalled result beat changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> out_granted_offset == '0)
    else $error("failed request carries an offset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE) || (out_status == ST_NOSPACE)
                  || (out_status == ST_IGNORED))
    else $error("undefined status code");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while a request is in work");

endmodule

bind first_fit_pool_allocator_top ffpa_chk u_ffpa_chk (.*);
